>>> sv/cmmc_pkg.sv
// Package with the shared constants, types and codes of the clique minor model checker.
package cmmc_pkg;

    localparam int VERTICES    = 12;
    localparam int BRANCH_SETS = 7;
    localparam int VIDX_W      = 4;
    localparam int SIDX_W      = 3;

    typedef logic [VERTICES-1:0] vmask_t;
    typedef logic [SIDX_W-1:0]   sidx_t;

    localparam sidx_t LAST_SET = sidx_t'(BRANCH_SETS - 1);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_OK           = 2'd0,
        VERDICT_DISCONNECTED = 2'd1,
        VERDICT_NOT_ADJACENT = 2'd2
    } verdict_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_GROW,
        ST_PAIR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                  valid;
        logic [VIDX_W-1:0]     index;
        vmask_t                mask;
    } row_write_t;

endpackage

>>> sv/cmmc_if.sv
// Handshake channel interfaces for command beats and result beats.
interface cmmc_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [3:0]  row_index;
    logic [11:0] row_mask;
    logic [11:0] branch_0;
    logic [11:0] branch_1;
    logic [11:0] branch_2;
    logic [11:0] branch_3;
    logic [11:0] branch_4;
    logic [11:0] branch_5;
    logic [11:0] branch_6;

    modport source (
        output valid, opcode, row_index, row_mask,
        output branch_0, branch_1, branch_2, branch_3, branch_4, branch_5, branch_6,
        input  ready
    );
    modport sink (
        input  valid, opcode, row_index, row_mask,
        input  branch_0, branch_1, branch_2, branch_3, branch_4, branch_5, branch_6,
        output ready
    );
endinterface

interface cmmc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;
    logic [2:0] failing_branch;

    modport source (output valid, verdict, failing_branch, input ready);
    modport sink (input valid, verdict, failing_branch, output ready);
endinterface

>>> sv/clique_minor_model_check.sv
// Top level of the clique minor model checker over a stored adjacency graph.
//
//  Channel | Role | Beat contents
//  cmd     | in   | opcode, row_index, row_mask, branch_0 .. branch_6
//  res     | out  | verdict, failing_branch (one beat per check, none per load)
//
// A load beat writes its row at the accepting edge; a row index past the last vertex is ignored.
// A check beat seeds each branch set's closure with its lowest vertex and grows it in rounds
// through the shared neighbour unit until it stops, then runs the pair test on each
// later set and hands over the result; a disconnected set ends the check early.
// Reset clears all adjacency rows, the sequencer state and the result valid flag.
// The command side is held off while a check runs; a waiting result only stalls
// the next check in its ST_DONE hand-over.
module clique_minor_model_check
    import cmmc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    cmmc_in_if.sink    cmd,
    cmmc_out_if.source res
);

    logic       idle;
    logic       accept;
    row_write_t wr;
    vmask_t     query;
    vmask_t     neighbours;
    vmask_t     sets_in [BRANCH_SETS];
    verdict_t   res_verdict;
    sidx_t      res_branch;

    assign cmd.ready = idle;
    assign accept    = cmd.valid && idle;

    assign wr.valid = accept && (cmd.opcode == OP_LOAD)
                      && (cmd.row_index < VIDX_W'(VERTICES));
    assign wr.index = cmd.row_index;
    assign wr.mask  = cmd.row_mask[VERTICES-1:0];

    assign sets_in[0] = cmd.branch_0[VERTICES-1:0];
    assign sets_in[1] = cmd.branch_1[VERTICES-1:0];
    assign sets_in[2] = cmd.branch_2[VERTICES-1:0];
    assign sets_in[3] = cmd.branch_3[VERTICES-1:0];
    assign sets_in[4] = cmd.branch_4[VERTICES-1:0];
    assign sets_in[5] = cmd.branch_5[VERTICES-1:0];
    assign sets_in[6] = cmd.branch_6[VERTICES-1:0];

    cmmc_adj_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .query      (query),
        .neighbours (neighbours)
    );

    cmmc_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (accept && (cmd.opcode == OP_CHECK)),
        .sets_in     (sets_in),
        .neighbours  (neighbours),
        .query       (query),
        .idle        (idle),
        .res_valid   (res.valid),
        .res_ready   (res.ready),
        .res_verdict (res_verdict),
        .res_branch  (res_branch)
    );

    assign res.verdict        = res_verdict;
    assign res.failing_branch = res_branch;

endmodule

>>> sv/cmmc_adj_store.sv
// Adjacency row registers and the shared neighbour unit that ORs the rows of a vertex mask.
module cmmc_adj_store
    import cmmc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  row_write_t wr,
    input  vmask_t     query,
    output vmask_t     neighbours
);

    vmask_t rows_reg [VERTICES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int x = 0; x < VERTICES; x++)
            begin
                rows_reg[x] <= '0;
            end
        end
        else if (wr.valid)
        begin
            rows_reg[wr.index] <= wr.mask;
        end
    end

    always_comb
    begin
        neighbours = '0;
        for (int x = 0; x < VERTICES; x++)
        begin
            if (query[x])
            begin
                neighbours = neighbours | rows_reg[x];
            end
        end
    end

endmodule

>>> sv/cmmc_seq.sv
// Sequencer that grows each branch closure, runs the pair test and holds the result beat.
module cmmc_seq
    import cmmc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  vmask_t   sets_in [BRANCH_SETS],
    input  vmask_t   neighbours,
    output vmask_t   query,
    output logic     idle,
    output logic     res_valid,
    input  logic     res_ready,
    output verdict_t res_verdict,
    output sidx_t    res_branch
);

    state_t   state_reg, state_next;
    vmask_t   sets_reg [BRANCH_SETS];
    sidx_t    idx_reg, idx_next;
    vmask_t   reach_reg, reach_next;
    verdict_t verdict_reg, verdict_next;
    sidx_t    fail_reg, fail_next;
    logic     out_valid_reg, out_valid_next;
    verdict_t out_verdict_reg, out_verdict_next;
    sidx_t    out_branch_reg, out_branch_next;

    vmask_t   cur_set;
    vmask_t   grown;
    logic     miss;

    assign cur_set = sets_reg[idx_reg];
    assign grown   = reach_reg | (neighbours & cur_set);
    assign query   = (state_reg == ST_PAIR) ? cur_set : reach_reg;

    always_comb
    begin
        miss = 1'b0;
        for (int j = 0; j < BRANCH_SETS; j++)
        begin
            if ((sidx_t'(j) < idx_reg) && ((neighbours & sets_reg[j]) == '0))
            begin
                miss = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            for (int i = 0; i < BRANCH_SETS; i++)
            begin
                sets_reg[i] <= sets_in[i];
            end
        end
        idx_reg         <= idx_next;
        reach_reg       <= reach_next;
        verdict_reg     <= verdict_next;
        fail_reg        <= fail_next;
        out_verdict_reg <= out_verdict_next;
        out_branch_reg  <= out_branch_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        reach_next       = reach_reg;
        verdict_next     = verdict_reg;
        fail_next        = fail_reg;
        out_valid_next   = out_valid_reg && !res_ready;
        out_verdict_next = out_verdict_reg;
        out_branch_next  = out_branch_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    idx_next   = '0;
                    state_next = ST_SEED;
                end
            end
            ST_SEED:
            begin
                reach_next = cur_set & (vmask_t'(~cur_set) + vmask_t'(1));
                state_next = ST_GROW;
            end
            ST_GROW:
            begin
                if (grown != reach_reg)
                begin
                    reach_next = grown;
                end
                else if (reach_reg != cur_set)
                begin
                    verdict_next = VERDICT_DISCONNECTED;
                    fail_next    = idx_reg;
                    state_next   = ST_DONE;
                end
                else if (idx_reg == LAST_SET)
                begin
                    idx_next   = sidx_t'(1);
                    state_next = ST_PAIR;
                end
                else
                begin
                    idx_next   = idx_reg + sidx_t'(1);
                    state_next = ST_SEED;
                end
            end
            ST_PAIR:
            begin
                if (miss)
                begin
                    verdict_next = VERDICT_NOT_ADJACENT;
                    fail_next    = idx_reg;
                    state_next   = ST_DONE;
                end
                else if (idx_reg == LAST_SET)
                begin
                    verdict_next = VERDICT_OK;
                    fail_next    = '0;
                    state_next   = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + sidx_t'(1);
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    out_valid_next   = 1'b1;
                    out_verdict_next = verdict_reg;
                    out_branch_next  = fail_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign idle        = (state_reg == ST_IDLE);
    assign res_valid   = out_valid_reg;
    assign res_verdict = out_verdict_reg;
    assign res_branch  = out_branch_reg;

endmodule

>>> verif/clique_minor_model_check_test.sv
// Self-checking testbench for the clique minor model checker: row loads, partition checks, random stalls.
module clique_minor_model_check_test;
    timeunit 1ns;
    timeprecision 1ps;
    import cmmc_pkg::*;

    localparam int RANDOM_BEATS = 1125;
    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 600;
    localparam int TAIL_CYCLES  = 200;
    localparam int REPORT_LIMIT = 10;

    typedef logic [BRANCH_SETS-1:0][VERTICES-1:0] branch_vec_t;
    typedef logic [VERTICES-1:0][3:0]             order_t;

    typedef struct packed {
        logic              opcode;
        logic [VIDX_W-1:0] row_index;
        vmask_t            row_mask;
        branch_vec_t       branches;
    } beat_t;

    typedef struct packed {
        verdict_t verdict;
        sidx_t    branch;
    } result_t;

    typedef struct {
        beat_t   beat;
        bit      typed;
        result_t want;
    } plan_row_t;

    localparam result_t NO_RESULT = '{verdict: VERDICT_OK, branch: '0};
    localparam branch_vec_t SINGLES = {12'h040, 12'h020, 12'h010, 12'h008,
                                       12'h004, 12'h002, 12'h001};
    localparam branch_vec_t REVERSED = {12'h001, 12'h002, 12'h004, 12'h008,
                                        12'h010, 12'h020, 12'h040};

    logic clk;
    logic rst_n;

    cmmc_in_if  cmd ();
    cmmc_out_if res ();

    clique_minor_model_check DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res)
    );

    vmask_t    graph_rows [VERTICES];
    result_t   verdicts_due [$];
    plan_row_t plan [$];

    int  burst_left;
    bit  pause_for_results;
    int  loads_sent;
    int  stray_loads;
    int  checks_sent;
    int  results_taken;
    int  mismatches;
    int  quiet_cycles;
    int  verdict_tally [3];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic vmask_t neighbours_of(vmask_t s);
        vmask_t acc;
        acc = '0;
        for (int x = 0; x < VERTICES; x++)
        begin
            if (s[x])
                acc |= graph_rows[x];
        end
        return acc;
    endfunction

    function automatic bit is_connected(vmask_t s);
        vmask_t reach;
        vmask_t grown;
        reach = s & (-s);
        for (int r = 0; r < VERTICES; r++)
        begin
            grown = reach | (neighbours_of(reach) & s);
            if (grown == reach)
                break;
            reach = grown;
        end
        return reach == s;
    endfunction

    function automatic result_t judge_partition(branch_vec_t sets);
        vmask_t nb;
        for (int i = 0; i < BRANCH_SETS; i++)
        begin
            if (!is_connected(sets[i]))
                return '{verdict: VERDICT_DISCONNECTED, branch: sidx_t'(i)};
        end
        for (int i = 1; i < BRANCH_SETS; i++)
        begin
            nb = neighbours_of(sets[i]);
            for (int j = 0; j < i; j++)
            begin
                if ((nb & sets[j]) == '0)
                    return '{verdict: VERDICT_NOT_ADJACENT, branch: sidx_t'(i)};
            end
        end
        return NO_RESULT;
    endfunction

    function automatic beat_t load_beat(logic [VIDX_W-1:0] idx, vmask_t mask);
        beat_t b;
        b.opcode    = OP_LOAD;
        b.row_index = idx;
        b.row_mask  = mask;
        for (int i = 0; i < BRANCH_SETS; i++)
            b.branches[i] = vmask_t'($urandom);
        return b;
    endfunction

    function automatic beat_t check_beat(branch_vec_t sets);
        beat_t b;
        b.opcode    = OP_CHECK;
        b.row_index = VIDX_W'($urandom_range(0, 15));
        b.row_mask  = vmask_t'($urandom);
        b.branches  = sets;
        return b;
    endfunction

    function automatic order_t shuffled();
        order_t     p;
        int         j;
        logic [3:0] t;
        for (int k = 0; k < VERTICES; k++)
            p[k] = 4'(k);
        for (int k = VERTICES - 1; k > 0; k--)
        begin
            j = $urandom_range(0, k);
            t = p[k];
            p[k] = p[j];
            p[j] = t;
        end
        return p;
    endfunction

    // Contiguous partitions follow the walk; scattered ones seed every set with one vertex.
    function automatic branch_vec_t partition_of(order_t p, bit contiguous);
        branch_vec_t s;
        int          idx;
        s = '0;
        idx = 0;
        for (int k = 0; k < VERTICES; k++)
        begin
            if (contiguous)
            begin
                s[idx] |= vmask_t'(1) << p[k];
                if (idx < BRANCH_SETS - 1 && $urandom_range(0, 2) == 0)
                    idx++;
            end
            else if (k < BRANCH_SETS)
            begin
                s[k] = vmask_t'(1) << p[k];
            end
            else
            begin
                idx = $urandom_range(0, BRANCH_SETS);
                if (idx < BRANCH_SETS)
                    s[idx] |= vmask_t'(1) << p[k];
            end
        end
        return s;
    endfunction

    function automatic vmask_t style_mask(int style);
        if (style == 0)
            return vmask_t'($urandom | $urandom | $urandom);
        return vmask_t'($urandom & $urandom & $urandom);
    endfunction

    task automatic add_load(logic [VIDX_W-1:0] idx, vmask_t mask);
        plan.insert(plan.size(), '{beat: load_beat(idx, mask), typed: 1'b0, want: NO_RESULT});
    endtask

    task automatic add_check(branch_vec_t sets, bit typed, verdict_t v, sidx_t fb);
        plan.insert(plan.size(), '{beat: check_beat(sets), typed: typed,
                                   want: '{verdict: v, branch: fb}});
    endtask

    task automatic offer(beat_t b, bit typed, result_t want);
        if (burst_left == 0)
        begin
            cmd.valid <= 1'b0;
            if (pause_for_results)
            begin
                pause_for_results = 1'b0;
                while (verdicts_due.size() != 0)
                    @(posedge clk);
            end
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        cmd.valid     <= 1'b1;
        cmd.opcode    <= b.opcode;
        cmd.row_index <= b.row_index;
        cmd.row_mask  <= b.row_mask;
        cmd.branch_0  <= b.branches[0];
        cmd.branch_1  <= b.branches[1];
        cmd.branch_2  <= b.branches[2];
        cmd.branch_3  <= b.branches[3];
        cmd.branch_4  <= b.branches[4];
        cmd.branch_5  <= b.branches[5];
        cmd.branch_6  <= b.branches[6];
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        burst_left--;
        if (b.opcode == OP_LOAD)
        begin
            loads_sent++;
            if (b.row_index < VERTICES)
                graph_rows[b.row_index] = b.row_mask;
            else
                stray_loads++;
        end
        else
        begin
            checks_sent++;
            verdicts_due.insert(verdicts_due.size(),
                                typed ? want : judge_partition(b.branches));
        end
    endtask

    always @(posedge clk)
    begin : take_results
        result_t due;
        if (rst_n)
        begin
            if (res.valid && res.ready)
            begin
                results_taken++;
                if (res.verdict < 3)
                    verdict_tally[res.verdict]++;
                if (verdicts_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: unexpected result beat: verdict %0d branch %0d",
                                 $time, res.verdict, res.failing_branch);
                end
                else
                begin
                    due = verdicts_due.pop_front();
                    if (res.verdict !== due.verdict || res.failing_branch !== due.branch)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t: expected %0d/%0d, got %0d/%0d (verdict/branch)",
                                     $time, due.verdict, due.branch, res.verdict,
                                     res.failing_branch);
                    end
                end
            end
            if ((cmd.valid && cmd.ready) || (res.valid && res.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial
    begin : result_side
        int tick;
        int mode;
        bit held;
        tick = 0;
        mode = 0;
        held = 1'b0;
        res.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (tick % 64 == 0)
                mode = $urandom_range(0, 3);
            if (!held && results_taken >= 200)
            begin
                held = 1'b1;
                res.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                case (mode)
                    0:       res.ready <= 1'b1;
                    1:       res.ready <= $urandom_range(0, 1);
                    2:       res.ready <= (tick % 4 == 0);
                    default: res.ready <= ($urandom_range(0, 6) != 0);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        do
            @(posedge clk);
        while (quiet_cycles < QUIET_LIMIT);
        $display("No beat moved on either channel for %0d cycles.", QUIET_LIMIT);
        $display("clique_minor_model_check_test failed");
        $finish;
    end

    initial
    begin : stimulus
        int          v;
        int          style;
        int          shape;
        int          issued;
        int          phase_left;
        bit          drained;
        order_t      walk;
        branch_vec_t sets;
        vmask_t      path_rows [VERTICES];

        burst_left = 0;
        pause_for_results = 1'b0;
        loads_sent = 0;
        stray_loads = 0;
        checks_sent = 0;
        results_taken = 0;
        mismatches = 0;
        quiet_cycles = 0;
        verdict_tally = '{0, 0, 0};
        for (int x = 0; x < VERTICES; x++)
            graph_rows[x] = '0;

        rst_n         <= 1'b0;
        cmd.valid     <= 1'b0;
        cmd.opcode    <= OP_LOAD;
        cmd.row_index <= '0;
        cmd.row_mask  <= '0;
        cmd.branch_0  <= '0;
        cmd.branch_1  <= '0;
        cmd.branch_2  <= '0;
        cmd.branch_3  <= '0;
        cmd.branch_4  <= '0;
        cmd.branch_5  <= '0;
        cmd.branch_6  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        add_check('0, 1'b1, VERDICT_NOT_ADJACENT, 3'd1);
        add_check({{6{12'h000}}, 12'h003}, 1'b1, VERDICT_DISCONNECTED, 3'd0);
        add_check({12'hFFF, SINGLES[5:0]}, 1'b1, VERDICT_DISCONNECTED, 3'd6);
        add_load(4'd12, 12'hFFF);
        add_load(4'd15, 12'hFFF);
        for (v = 0; v < BRANCH_SETS; v++)
            add_load(VIDX_W'(v), 12'h07F & ~(vmask_t'(1) << v));
        add_check(SINGLES, 1'b1, VERDICT_OK, 3'd0);
        add_load(4'd11, 12'hFFF);
        add_load(4'd0, 12'h000);
        add_check(SINGLES, 1'b0, VERDICT_OK, 3'd0);
        add_check(REVERSED, 1'b0, VERDICT_OK, 3'd0);
        sets = SINGLES;
        sets[3] = '0;
        add_check(sets, 1'b0, VERDICT_OK, 3'd0);
        add_check({{6{12'h000}}, 12'h801}, 1'b0, VERDICT_OK, 3'd0);
        add_check({{6{12'h000}}, 12'h880}, 1'b0, VERDICT_OK, 3'd0);
        add_load(4'd0, 12'hFFF);
        add_check('1, 1'b0, VERDICT_OK, 3'd0);
        add_check({SINGLES[6:1], 12'hFFF}, 1'b0, VERDICT_OK, 3'd0);
        foreach (plan[k])
            offer(plan[k].beat, plan[k].typed, plan[k].want);

        issued = 0;
        drained = 1'b0;
        while (issued < RANDOM_BEATS)
        begin
            // Styles: dense, sparse, two-way path and one-way path over a random walk.
            style = $urandom_range(0, 3);
            walk = shuffled();
            for (int x = 0; x < VERTICES; x++)
                path_rows[x] = '0;
            for (int k = 0; k < VERTICES; k++)
            begin
                if (k + 1 < VERTICES)
                    path_rows[walk[k]] |= vmask_t'(1) << walk[k + 1];
                if (style == 2 && k > 0)
                    path_rows[walk[k]] |= vmask_t'(1) << walk[k - 1];
            end
            for (v = 0; v < VERTICES; v++)
            begin
                offer(load_beat(VIDX_W'(v), (style < 2) ? style_mask(style) : path_rows[v]),
                      1'b0, NO_RESULT);
                issued++;
            end
            phase_left = $urandom_range(20, 60);
            while (phase_left > 0 && issued < RANDOM_BEATS)
            begin
                if (!drained && issued >= RANDOM_BEATS / 2)
                begin
                    drained = 1'b1;
                    pause_for_results = 1'b1;
                    burst_left = 0;
                end
                if ($urandom_range(0, 99) < 12)
                begin
                    v = ($urandom_range(0, 7) == 0) ? $urandom_range(VERTICES, 15)
                                                    : $urandom_range(0, VERTICES - 1);
                    offer(load_beat(VIDX_W'(v),
                                    (style < 2) ? style_mask(style) : vmask_t'($urandom)),
                          1'b0, NO_RESULT);
                    if (v < VERTICES)
                        issued++;
                end
                else
                begin
                    shape = $urandom_range(0, 99);
                    sets = (style < 2) ? partition_of(shuffled(), 1'b0)
                                       : partition_of(walk, 1'b1);
                    if (style >= 2 && shape < 10)
                        sets[0] = '1;
                    else if (shape >= 65 && shape < 75)
                        sets[$urandom_range(0, BRANCH_SETS - 1)] = '0;
                    else if (shape >= 75 && shape < 82)
                        sets[$urandom_range(0, BRANCH_SETS - 1)] |=
                            vmask_t'(1) << $urandom_range(0, VERTICES - 1);
                    else if (shape >= 82 && shape < 92)
                    begin
                        for (int k = 0; k < BRANCH_SETS; k++)
                            sets[k] = vmask_t'($urandom & $urandom);
                    end
                    else if (shape >= 92)
                    begin
                        for (int k = 0; k < BRANCH_SETS; k++)
                        begin
                            case ($urandom_range(0, 2))
                                0:       sets[k] = '0;
                                1:       sets[k] = '1;
                                default: sets[k] = vmask_t'($urandom);
                            endcase
                        end
                    end
                    offer(check_beat(sets), 1'b0, NO_RESULT);
                    issued++;
                end
                phase_left--;
            end
        end

        cmd.valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d row loads (%0d to absent vertices) and %0d checks.",
                 loads_sent, stray_loads, checks_sent);
        $display("Verdicts: %0d valid, %0d disconnected, %0d not adjacent; %0d mismatches.",
                 verdict_tally[0], verdict_tally[1], verdict_tally[2], mismatches);
        if (mismatches == 0 && verdicts_due.size() == 0)
            $display("clique_minor_model_check_test passed");
        else
            $display("clique_minor_model_check_test failed");
        $finish;
    end

endmodule

>>> sim.f
sv/cmmc_pkg.sv
sv/cmmc_if.sv
sv/cmmc_adj_store.sv
sv/cmmc_seq.sv
sv/clique_minor_model_check.sv
verif/clique_minor_model_check_test.sv
